// ===== design/febu_pkg.sv =====
// Shared constants, types and the CORDIC angle table of the flat earth bearing unit.
// Depends on nothing.
package febu_pkg;

  localparam int CORDIC_STAGES_DEFAULT = 32;
  localparam int MAX_STAGES = 48;

  localparam int LAT_W = 31;
  localparam int LON_W = 32;
  localparam int COURSE_W = 32;

  localparam int RX_W = 44;   // rotation x/y, Q40
  localparam int ANG_W = 50;  // engine angle, 2^-16 of 1e-7 degree
  localparam int VX_W = 64;   // vectoring x/y
  localparam int COS_W = 30;  // signed Q28 cosine
  localparam int DLON_W = LON_W + 1;
  localparam int DLAT_W = LAT_W + 1;

  localparam logic signed [ANG_W-1:0] FULL_TURN = 50'sd235929600000000;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 50'sd58982400000000;
  localparam logic signed [ANG_W-1:0] EIGHTH_TURN = 50'sd29491200000000;
  localparam logic signed [LAT_W+1:0] HALF_TURN_DEG7 = 33'sd1800000000;
  localparam logic signed [LAT_W+1:0] QUARTER_TURN_DEG7 = 33'sd900000000;
  localparam logic [63:0] RAD_TO_UNIT = 64'd37549362061694;
  localparam logic signed [RX_W-1:0] CORDIC_START_X = 44'sh09B74EDA800;
  localparam logic [ANG_W-15:0] COURSE_LIMIT = 36'd3600000000;

  typedef struct packed {
    logic signed [DLON_W-1:0] dlon;
    logic signed [DLAT_W-1:0] dlat;
    logic                     neg;
  } rot_side_t;

  function automatic logic signed [ANG_W-1:0] angle_entry(input int i);
    logic [63:0] scaled;
    logic [63:0] sum;
    logic [63:0] t;
    int sh;
    scaled = RAD_TO_UNIT << 16;
    sum = '0;
    if (i == 0) begin
      return EIGHTH_TURN;
    end
    for (int k = 0; k < 62; k++) begin
      sh = i * (2 * k + 1);
      if (sh < 62) begin
        t = (scaled >> sh) / 64'(2 * k + 1);
        if (k % 2 == 1) sum = sum - t;
        else sum = sum + t;
      end
    end
    sum = (sum + 64'd32768) >> 16;
    return sum[ANG_W-1:0];
  endfunction

endpackage

// ===== design/febu_if.sv =====
// Valid/ready channel interfaces for positions in and bearings out.
// Depends on febu_pkg.
interface febu_in_if import febu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] start_latitude;
  logic signed [LON_W-1:0] start_longitude;
  logic signed [LAT_W-1:0] end_latitude;
  logic signed [LON_W-1:0] end_longitude;
  modport source (output valid, start_latitude, start_longitude, end_latitude,
                  end_longitude, input ready);
  modport sink (input valid, start_latitude, start_longitude, end_latitude,
                end_longitude, output ready);
endinterface

interface febu_out_if import febu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COURSE_W-1:0] course;
  logic                undefined_course;
  modport source (output valid, course, undefined_course, input ready);
  modport sink (input valid, course, undefined_course, output ready);
endinterface

// ===== design/febu_rot_cell.sv =====
// One rotation CORDIC cell of the cosine chain, with its side payload.
// Depends on febu_pkg.
module febu_rot_cell import febu_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    valid_in,
  input  logic signed [RX_W-1:0]  x_in,
  input  logic signed [RX_W-1:0]  y_in,
  input  logic signed [ANG_W-1:0] z_in,
  input  rot_side_t               side_in,
  output logic                    valid_out,
  output logic signed [RX_W-1:0]  x_out,
  output logic signed [RX_W-1:0]  y_out,
  output logic signed [ANG_W-1:0] z_out,
  output rot_side_t               side_out
);
  localparam logic signed [ANG_W-1:0] ANGLE = angle_entry(STAGE);

  logic signed [RX_W-1:0] xs, ys;
  assign xs = x_in >>> STAGE;
  assign ys = y_in >>> STAGE;

  always_ff @(posedge clk) begin
    if (rst) valid_out <= 1'b0;
    else if (en) valid_out <= valid_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= side_in;
      if (!z_in[ANG_W-1]) begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ANGLE;
      end else begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ANGLE;
      end
    end
  end
endmodule

// ===== design/febu_vec_cell.sv =====
// One vectoring CORDIC cell of the arctangent chain, with the undefined flag.
// Depends on febu_pkg.
module febu_vec_cell import febu_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    valid_in,
  input  logic signed [VX_W-1:0]  x_in,
  input  logic signed [VX_W-1:0]  y_in,
  input  logic signed [ANG_W-1:0] z_in,
  input  logic                    undef_in,
  output logic                    valid_out,
  output logic signed [VX_W-1:0]  x_out,
  output logic signed [VX_W-1:0]  y_out,
  output logic signed [ANG_W-1:0] z_out,
  output logic                    undef_out
);
  localparam logic signed [ANG_W-1:0] ANGLE = angle_entry(STAGE);

  logic signed [VX_W-1:0] xs, ys;
  assign xs = x_in >>> STAGE;
  assign ys = y_in >>> STAGE;

  always_ff @(posedge clk) begin
    if (rst) valid_out <= 1'b0;
    else if (en) valid_out <= valid_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      undef_out <= undef_in;
      if (!y_in[VX_W-1]) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ANGLE;
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ANGLE;
      end
    end
  end
endmodule

// ===== design/flat_earth_bearing_unit.sv =====
// Top level of the flat earth bearing unit: cosine chain, multiply, arctangent chain.
// Depends on febu_pkg, febu_if, febu_rot_cell and febu_vec_cell.
//
// Usage: a request on the position channel carries start and end latitude and
// longitude in 1e-7 degree. Each request gives one response on the bearing
// channel: the course clockwise from north in 1e-7 degree, and
// undefined_course when the east and north offsets are both zero, as when the
// two positions coincide (course then 0).
// Throughput is one request per cycle while the receiver takes responses:
// every stage is a register and the two CORDIC engines are rows of cells,
// one cell per iteration, each passing its result to the next cell every cycle.
// The whole pipeline advances together. When the receiver stalls a waiting
// response, the pipeline holds and position.ready drops until it is taken.
// Synchronous reset clears every valid bit; the pipeline is empty afterwards
// and ready in the first cycle after reset.
module flat_earth_bearing_unit import febu_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  febu_in_if.sink   position,
  febu_out_if.source bearing
);
  localparam int N = CORDIC_STAGES;

  logic en;
  assign en = !bearing.valid || bearing.ready;
  assign position.ready = en;

  // front: differences and latitude reduction
  logic signed [LAT_W+1:0] lat_abs, lat_red;
  logic                    lat_neg;
  always_comb begin
    lat_abs = position.start_latitude[LAT_W-1] ?
              -(LAT_W+2)'(position.start_latitude) : (LAT_W+2)'(position.start_latitude);
    lat_neg = lat_abs > QUARTER_TURN_DEG7;
    lat_red = lat_neg ? HALF_TURN_DEG7 - lat_abs : lat_abs;
  end

  logic                    rv [0:N];
  logic signed [RX_W-1:0]  rx [0:N];
  logic signed [RX_W-1:0]  ry [0:N];
  logic signed [ANG_W-1:0] rz [0:N];
  rot_side_t               rs [0:N];

  always_ff @(posedge clk) begin
    if (rst) rv[0] <= 1'b0;
    else if (en) rv[0] <= position.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx[0] <= CORDIC_START_X;
      ry[0] <= '0;
      rz[0] <= ANG_W'(lat_red) <<< 16;
      rs[0].dlon <= DLON_W'(position.end_longitude) - DLON_W'(position.start_longitude);
      rs[0].dlat <= DLAT_W'(position.end_latitude) - DLAT_W'(position.start_latitude);
      rs[0].neg <= lat_neg;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    febu_rot_cell #(.STAGE(i)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .valid_in(rv[i]), .x_in(rx[i]), .y_in(ry[i]), .z_in(rz[i]), .side_in(rs[i]),
      .valid_out(rv[i+1]), .x_out(rx[i+1]), .y_out(ry[i+1]), .z_out(rz[i+1]),
      .side_out(rs[i+1])
    );
  end

  // cosine rounding to Q28, clamp and sign
  logic signed [RX_W-1:0]  cos_round;
  logic signed [COS_W-1:0] cos_mag;
  always_comb begin
    cos_round = (rx[N] + RX_W'(2048)) >>> 12;
    cos_mag = cos_round[RX_W-1] ? '0 : cos_round[COS_W-1:0];
  end

  logic                     m1_valid;
  logic signed [COS_W-1:0]  m1_cos;
  logic signed [DLON_W-1:0] m1_dlon;
  logic signed [DLAT_W-1:0] m1_dlat;

  always_ff @(posedge clk) begin
    if (rst) m1_valid <= 1'b0;
    else if (en) m1_valid <= rv[N];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_cos <= rs[N].neg ? -cos_mag : cos_mag;
      m1_dlon <= rs[N].dlon;
      m1_dlat <= rs[N].dlat;
    end
  end

  // east and north offsets
  logic                   m2_valid;
  logic signed [VX_W-1:0] m2_east, m2_north;
  always_ff @(posedge clk) begin
    if (rst) m2_valid <= 1'b0;
    else if (en) m2_valid <= m1_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_east <= VX_W'(m1_cos) * VX_W'(m1_dlon);
      m2_north <= VX_W'(m1_dlat) <<< 28;
    end
  end

  // turn into the right half plane
  logic                    vv [0:N];
  logic signed [VX_W-1:0]  vx [0:N];
  logic signed [VX_W-1:0]  vy [0:N];
  logic signed [ANG_W-1:0] vz [0:N];
  logic                    vu [0:N];

  always_ff @(posedge clk) begin
    if (rst) vv[0] <= 1'b0;
    else if (en) vv[0] <= m2_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vu[0] <= (m2_east == '0) && (m2_north == '0);
      if (!m2_north[VX_W-1]) begin
        vx[0] <= m2_north;
        vy[0] <= m2_east;
        vz[0] <= '0;
      end else if (!m2_east[VX_W-1]) begin
        vx[0] <= m2_east;
        vy[0] <= -m2_north;
        vz[0] <= QUARTER_TURN;
      end else begin
        vx[0] <= -m2_east;
        vy[0] <= m2_north;
        vz[0] <= -QUARTER_TURN;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    febu_vec_cell #(.STAGE(i)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .valid_in(vv[i]), .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]), .undef_in(vu[i]),
      .valid_out(vv[i+1]), .x_out(vx[i+1]), .y_out(vy[i+1]), .z_out(vz[i+1]),
      .undef_out(vu[i+1])
    );
  end

  // wrap, round to 1e-7 degree, fold 360 to 0
  logic signed [ANG_W-1:0] z_wrap;
  logic [ANG_W-1:0]        z_sum;
  logic [ANG_W-15:0]       course_round;
  always_comb begin
    z_wrap = vz[N][ANG_W-1] ? vz[N] + FULL_TURN : vz[N];
    z_sum = z_wrap + ANG_W'(32768);
    course_round = z_sum[ANG_W-1:14] >> 2;
  end

  always_ff @(posedge clk) begin
    if (rst) bearing.valid <= 1'b0;
    else if (en) bearing.valid <= vv[N];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bearing.undefined_course <= vu[N];
      if (vu[N] || course_round >= COURSE_LIMIT) bearing.course <= '0;
      else bearing.course <= course_round[COURSE_W-1:0];
    end
  end

  // vx, vy of the last cell are not needed beyond the chain
  logic unused_tail;
  assign unused_tail = ^{vx[N], vy[N], ry[N], rz[N], rs[N].dlat[0]};

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (bearing.valid && !bearing.ready) |-> !position.ready)
    else $error("request accepted while response stalled");

  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    (bearing.valid && bearing.undefined_course) |-> (bearing.course == '0))
    else $error("undefined course with nonzero course");

  a_course_range: assert property (@(posedge clk) disable iff (rst)
    bearing.valid |-> (bearing.course < 32'd3600000000))
    else $error("course out of range");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (en && !vv[N]) |=> !bearing.valid)
    else $error("response without a request in the last cell");
endmodule

// ===== verif/tb_flat_earth_bearing_unit.sv =====
`timescale 1ns / 100ps
// Testbench for flat_earth_bearing_unit: directed and random position pairs,
// each course predicted in fixed point and checked in order under random idling.
// Depends on febu_pkg, febu_if and the flat_earth_bearing_unit RTL.
module tb_flat_earth_bearing_unit;
  import febu_pkg::*;

  localparam int STAGES = 32;
  localparam int LATENCY = 2 * STAGES + 5;
  localparam int CYCLE_LIMIT = 600000;
  localparam longint FULL_TURN_U = 64'sd235929600000000;
  localparam longint QUARTER_TURN_U = 64'sd58982400000000;
  localparam longint HALF_TURN_D7 = 64'sd1800000000;
  localparam longint QUARTER_TURN_D7 = 64'sd900000000;
  localparam longint COURSE_WRAP = 64'sd3600000000;
  localparam longint COS_START_X = 64'sh9B74EDA800;
  localparam longint unsigned RAD_SCALED = 64'd37549362061694 << 16;

  typedef struct {
    logic signed [LAT_W-1:0] start_latitude;
    logic signed [LON_W-1:0] start_longitude;
    logic signed [LAT_W-1:0] end_latitude;
    logic signed [LON_W-1:0] end_longitude;
  } position_t;

  typedef struct {
    logic [COURSE_W-1:0] course;
    logic                undefined_course;
  } bearing_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  febu_in_if position ();
  febu_out_if bearing ();

  flat_earth_bearing_unit #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk),
    .rst(rst),
    .position(position),
    .bearing(bearing)
  );

  always #5 clk = ~clk;

  longint atan_step[STAGES];
  bearing_t pending_bearings[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int cycles = 0;
  bit failed = 1'b0;

  function automatic longint atan_entry(int i);
    longint unsigned sum;
    longint unsigned t;
    int sh;
    sum = 0;
    if (i == 0) return QUARTER_TURN_U / 2;
    for (int k = 0; k < 62; k++) begin
      sh = i * (2 * k + 1);
      if (sh >= 62) break;
      t = (RAD_SCALED >> sh) / longint'(2 * k + 1);
      if (k % 2 == 1) sum = sum - t;
      else sum = sum + t;
    end
    return longint'((sum + 64'd32768) >> 16);
  endfunction

  function automatic longint latitude_cosine(longint lat);
    longint a, x, y, z, xs, ys, c;
    bit neg;
    a = lat < 0 ? -lat : lat;
    neg = 1'b0;
    if (a > QUARTER_TURN_D7) begin
      a = HALF_TURN_D7 - a;
      neg = 1'b1;
    end
    x = COS_START_X;
    y = 0;
    z = a * 65536;
    for (int s = 0; s < STAGES; s++) begin
      xs = x >>> s;
      ys = y >>> s;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_step[s];
      end else begin
        x = x + ys; y = y - xs; z = z + atan_step[s];
      end
    end
    c = (x + 2048) >>> 12;
    if (c < 0) c = 0;
    return neg ? -c : c;
  endfunction

  function automatic bearing_t predict_bearing(position_t p);
    bearing_t r;
    longint east, north, x, y, z, xs, ys, t, c;
    east = latitude_cosine(longint'(p.start_latitude)) *
           (longint'(p.end_longitude) - longint'(p.start_longitude));
    north = (longint'(p.end_latitude) - longint'(p.start_latitude)) * 268435456;
    if (east == 0 && north == 0) begin
      r.course = '0;
      r.undefined_course = 1'b1;
      return r;
    end
    x = north; y = east; z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = QUARTER_TURN_U;
      end else begin
        x = -y; y = t; z = -QUARTER_TURN_U;
      end
    end
    for (int s = 0; s < STAGES; s++) begin
      xs = x >>> s;
      ys = y >>> s;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + atan_step[s];
      end else begin
        x = x - ys; y = y + xs; z = z - atan_step[s];
      end
    end
    if (z < 0) z = z + FULL_TURN_U;
    c = (z + 32768) >>> 16;
    if (c >= COURSE_WRAP) c = 0;
    r.course = c[31:0];
    r.undefined_course = 1'b0;
    return r;
  endfunction

  function automatic position_t make_position(longint lat_s, longint lon_s,
                                              longint lat_e, longint lon_e);
    position_t p;
    p.start_latitude = lat_s[LAT_W-1:0];
    p.start_longitude = lon_s[LON_W-1:0];
    p.end_latitude = lat_e[LAT_W-1:0];
    p.end_longitude = lon_e[LON_W-1:0];
    return p;
  endfunction

  function automatic longint rand_lat();
    return longint'($urandom_range(1800000000)) - 900000000;
  endfunction

  function automatic longint rand_lon();
    return longint'($urandom_range(32'd3600000000)) - 1800000000;
  endfunction

  function automatic position_t random_position();
    position_t p;
    longint lat, lon;
    int pick;
    pick = $urandom_range(99);
    lat = rand_lat();
    lon = rand_lon();
    if (pick < 60) begin
      p = make_position(lat, lon, rand_lat(), rand_lon());
    end else if (pick < 75) begin
      // nearby end point, small offsets
      p = make_position(lat, lon, lat + $signed($urandom_range(2000)) - 1000,
                        lon + $signed($urandom_range(2000)) - 1000);
    end else if (pick < 82) begin
      p = make_position(lat, lon, lat, lon);
    end else if (pick < 88) begin
      p = make_position(($urandom_range(1) ? 900000000 : -900000000), lon,
                        lat, rand_lon());
    end else begin
      p.start_latitude = LAT_W'($urandom());
      p.start_longitude = $urandom();
      p.end_latitude = LAT_W'($urandom());
      p.end_longitude = $urandom();
    end
    return p;
  endfunction

  task automatic send_position(position_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      position.valid <= 1'b0;
      @(posedge clk);
    end
    position.valid <= 1'b1;
    position.start_latitude <= p.start_latitude;
    position.start_longitude <= p.start_longitude;
    position.end_latitude <= p.end_latitude;
    position.end_longitude <= p.end_longitude;
    do @(posedge clk); while (!position.ready);
    pending_bearings.push_back(predict_bearing(p));
  endtask

  task automatic release_sender();
    position.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_bearings.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    send_position(make_position(0, 0, 0, 0));
    send_position(make_position(900000000, 5, 900000000, 1000000));
    send_position(make_position(-900000000, 0, -899999999, 1800000000));
    send_position(make_position(0, 0, 1, 0));
    send_position(make_position(0, 0, -1, 0));
    send_position(make_position(0, 0, 0, 1));
    send_position(make_position(0, 0, 0, -1));
    send_position(make_position(0, 0, 10, 10));
    send_position(make_position(0, 0, -10, 10));
    send_position(make_position(0, 0, -10, -10));
    send_position(make_position(0, 0, 10, -10));
    send_position(make_position(0, 0, 1000, -1));
    send_position(make_position(0, 0, -1000, 1));
    send_position(make_position(0, 0, -1000, -1));
    send_position(make_position(-900000000, -1800000000, 900000000, 1800000000));
    send_position(make_position(900000000, 1800000000, -900000000, -1800000000));
    send_position(make_position(0, 1790000000, 0, -1790000000));
    send_position(make_position(1000000000, 0, 1000000000, 100));
    send_position(make_position(-1073741824, 0, 1073741823, 7));
    send_position(make_position(1073741823, -2147483647 - 1, -1073741824, 2147483647));
    send_position(make_position(450000000, 0, 450000000, 100000));
    send_position(make_position(0, 0, 1000000, -1));
    release_sender();
  endtask

  task automatic test_random(int count, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) send_position(random_position());
    release_sender();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_len = 400;
    for (int i = 0; i < 150; i++) send_position(random_position());
    release_sender();
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 20;
    stall_pct = 20;
    for (int i = 0; i < 20; i++) send_position(random_position());
    release_sender();
    wait_drained();
    for (int i = 0; i < 20; i++) send_position(random_position());
    release_sender();
  endtask

  initial begin
    int hold;
    bearing.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        hold = hold_len;
        hold_len = 0;
        bearing.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      bearing.ready <= ($urandom_range(99) >= stall_pct);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    bearing_t want;
    if (!rst && bearing.valid && bearing.ready) begin
      if (pending_bearings.size() == 0) begin
        $display("%0t: unexpected bearing course=%0d undefined=%0b", $time,
                 bearing.course, bearing.undefined_course);
        failed = 1'b1;
      end else begin
        want = pending_bearings.pop_front();
        if (bearing.course !== want.course) begin
          $display("%0t: course expected %0d actual %0d", $time, want.course,
                   bearing.course);
          failed = 1'b1;
        end
        if (bearing.undefined_course !== want.undefined_course) begin
          $display("%0t: undefined_course expected %0b actual %0b", $time,
                   want.undefined_course, bearing.undefined_course);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[flat_earth_bearing_unit] ERROR");
      $finish;
    end
  end

  initial begin
    position.valid = 1'b0;
    position.start_latitude = '0;
    position.start_longitude = '0;
    position.end_latitude = '0;
    position.end_longitude = '0;
    for (int i = 0; i < STAGES; i++) atan_step[i] = atan_entry(i);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400, 0, 0);
    test_random(350, 84, 0);
    test_random(350, 0, 84);
    test_random(350, 20, 20);
    test_backpressure();
    test_drain_pause();
    test_random(150, 0, 0);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (!failed && pending_bearings.size() == 0) begin
      $display("[flat_earth_bearing_unit] OK");
    end else begin
      $display("[flat_earth_bearing_unit] ERROR");
    end
    $finish;
  end

endmodule
